FILE: rtl/core/nwpt_pkg.sv
`timescale 1ns / 1ps

package nwpt_pkg;

	localparam int MAX_WAYPOINTS_DEF = 32;
	localparam int COORD_BITS_DEF    = 24;
	localparam int HEAD_W            = 16;
	localparam int INDEX_W           = 6;
	localparam int KIND_W            = 2;
	localparam int STATUS_W          = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_APPEND  = 2'd1,
		KIND_GOAL    = 2'd2,
		KIND_NEAREST = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT,
		ST_GOAL
	} state_t;

endpackage

FILE: rtl/core/nearest_waypoint_path_truncation_top.sv
`timescale 1ns / 1ps
// Clear and append requests are handled as they are accepted; an append to a full table returns one status result.
// A query over n stored waypoints scans them with one shared squarer, squaring dx then dy for each;
// the drain state settles the last compare, then points go out one per cycle unless the output stalls
// (n + 1 points at most); a goal query emits waypoints 0 to k, k the nearest index, then the goal.
// Reset clears the waypoint count and the control state; the waypoint memory is not cleared.
module nearest_waypoint_path_truncation_top #(
	parameter int MAX_WAYPOINTS = nwpt_pkg::MAX_WAYPOINTS_DEF,
	parameter int COORD_BITS    = nwpt_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [nwpt_pkg::KIND_W-1:0]         kind,
	input  logic signed [COORD_BITS-1:0]        pos_x,
	input  logic signed [COORD_BITS-1:0]        pos_y,
	input  logic signed [nwpt_pkg::HEAD_W-1:0]  heading,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        out_x,
	output logic signed [COORD_BITS-1:0]        out_y,
	output logic signed [nwpt_pkg::HEAD_W-1:0]  out_heading,
	output logic [nwpt_pkg::INDEX_W-1:0]        point_index,
	output logic                                is_goal,
	output logic [nwpt_pkg::STATUS_W-1:0]       status,
	output logic                                last
);
	import nwpt_pkg::*;

	localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
	localparam int CB     = COORD_BITS;
	localparam int WORD_W = 2 * CB + HEAD_W;
	localparam int SQ_W   = 2 * CB;

	state_t state_q, state_d;

	logic [WORD_W-1:0] mem [MAX_WAYPOINTS];
	logic [WORD_W-1:0] rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_last;
	logic              full;
	logic              in_fire;
	logic              out_free;
	kind_t             kind_in;

	logic signed [CB-1:0]     goal_x_q, goal_y_q;
	logic signed [HEAD_W-1:0] goal_h_q;
	logic                     goal_query_q;

	logic signed [CB-1:0]     rd_x, rd_y;
	logic signed [HEAD_W-1:0] rd_h;
	logic signed [CB:0]       dxs, dys, dxn, dyn;
	logic [CB-1:0]            dx_abs, dy_abs, dy_q, mul_a;
	logic [SQ_W-1:0]          prod, sq_q, sqx_q;
	logic [SQ_W:0]            sum, best_d_q;

	logic             ph_q;
	logic [IDX_W-1:0] scan_idx_q, cur_idx_q, cmp_idx_q, best_q, best_next, emit_idx_q;
	logic             cmp_pend_q;
	logic             take;
	logic             scan_at_end, cur_at_end, emit_at_end;
	logic             load_out;
	logic [IDX_W+INDEX_W-1:0] idx_ext;
	logic [CNT_W+INDEX_W-1:0] cnt_ext;

	logic                     out_valid_q;
	logic signed [CB-1:0]     out_x_q, out_y_q;
	logic signed [HEAD_W-1:0] out_h_q;
	logic [INDEX_W-1:0]       out_idx_q;
	logic                     out_goal_q, out_last_q;
	status_t                  out_status_q;

	assign kind_in   = kind_t'(kind);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign full      = (count_q == CNT_W'(MAX_WAYPOINTS));
	assign cnt_last  = count_q - CNT_W'(1);

	assign rd_x = rd_q[WORD_W-1 -: CB];
	assign rd_y = rd_q[HEAD_W +: CB];
	assign rd_h = rd_q[HEAD_W-1:0];

	assign dxs    = {rd_x[CB-1], rd_x} - {goal_x_q[CB-1], goal_x_q};
	assign dys    = {rd_y[CB-1], rd_y} - {goal_y_q[CB-1], goal_y_q};
	assign dxn    = -dxs;
	assign dyn    = -dys;
	assign dx_abs = dxs[CB] ? dxn[CB-1:0] : dxs[CB-1:0];
	assign dy_abs = dys[CB] ? dyn[CB-1:0] : dys[CB-1:0];
	assign mul_a  = ph_q ? dy_q : dx_abs;
	assign prod   = mul_a * mul_a;

	assign sum       = {1'b0, sqx_q} + {1'b0, sq_q};
	assign take      = cmp_pend_q && ((cmp_idx_q == '0) || (sum < best_d_q));
	assign best_next = take ? cmp_idx_q : best_q;

	assign scan_at_end = (CNT_W'(scan_idx_q) == cnt_last);
	assign cur_at_end  = (CNT_W'(cur_idx_q) == cnt_last);
	assign emit_at_end = (emit_idx_q == best_q);

	assign idx_ext = {{INDEX_W{1'b0}}, emit_idx_q};
	assign cnt_ext = {{INDEX_W{1'b0}}, count_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (kind_in == KIND_GOAL || kind_in == KIND_NEAREST)
						&& count_q != '0)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (ph_q && cur_at_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free && emit_at_end)
					state_d = goal_query_q ? ST_GOAL : ST_IDLE;
			end
			ST_GOAL: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = !out_free;
				if (in_fire) begin
					case (kind_in)
						KIND_APPEND: begin
							mem_we   = !full;
							load_out = full;
						end
						KIND_GOAL, KIND_NEAREST: begin
							mem_re   = (count_q != '0);
							load_out = (count_q == '0);
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!ph_q && !scan_at_end) begin
					mem_re    = 1'b1;
					mem_raddr = scan_idx_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				mem_re    = 1'b1;
				mem_raddr = goal_query_q ? '0 : best_next;
			end
			ST_EMIT: begin
				load_out = out_free;
				if (out_free && !emit_at_end) begin
					mem_re    = 1'b1;
					mem_raddr = emit_idx_q + IDX_W'(1);
				end
			end
			ST_GOAL: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[count_q[IDX_W-1:0]] <= {pos_x, pos_y, heading};
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ph_q        <= 1'b0;
			cmp_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && kind_in == KIND_CLEAR)
				count_q <= '0;
			else if (mem_we)
				count_q <= count_q + CNT_W'(1);
			if (state_q == ST_SCAN)
				ph_q <= !ph_q;
			else
				ph_q <= 1'b0;
			cmp_pend_q <= (state_q == ST_SCAN) && ph_q;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			goal_x_q     <= pos_x;
			goal_y_q     <= pos_y;
			goal_h_q     <= heading;
			goal_query_q <= (kind_in == KIND_GOAL);
			scan_idx_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			sq_q <= prod;
			if (!ph_q) begin
				dy_q      <= dy_abs;
				cur_idx_q <= scan_idx_q;
				if (!scan_at_end)
					scan_idx_q <= scan_idx_q + IDX_W'(1);
			end else begin
				sqx_q     <= sq_q;
				cmp_idx_q <= cur_idx_q;
			end
		end
		if (take) begin
			best_q   <= cmp_idx_q;
			best_d_q <= sum;
		end
		if (state_q == ST_DRAIN)
			emit_idx_q <= goal_query_q ? '0 : best_next;
		else if (state_q == ST_EMIT && out_free && !emit_at_end)
			emit_idx_q <= emit_idx_q + IDX_W'(1);
		if (load_out) begin
			case (state_q)
				ST_EMIT: begin
					out_x_q      <= rd_x;
					out_y_q      <= rd_y;
					out_h_q      <= rd_h;
					out_idx_q    <= idx_ext[INDEX_W-1:0];
					out_goal_q   <= 1'b0;
					out_status_q <= STATUS_OK;
					out_last_q   <= emit_at_end && !goal_query_q;
				end
				ST_GOAL: begin
					out_x_q      <= goal_x_q;
					out_y_q      <= goal_y_q;
					out_h_q      <= goal_h_q;
					out_idx_q    <= cnt_ext[INDEX_W-1:0];
					out_goal_q   <= 1'b1;
					out_status_q <= STATUS_OK;
					out_last_q   <= 1'b1;
				end
				default: begin
					out_x_q      <= '0;
					out_y_q      <= '0;
					out_h_q      <= '0;
					out_idx_q    <= '0;
					out_goal_q   <= 1'b0;
					out_status_q <= (kind_in == KIND_APPEND) ? STATUS_FULL : STATUS_EMPTY;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_heading = out_h_q;
	assign point_index = out_idx_q;
	assign is_goal     = out_goal_q;
	assign status      = out_status_q;
	assign last        = out_last_q;

endmodule
